[rtl/rsa_pkg.sv]
`default_nettype none

package rsa_pkg;

	localparam int FREE_DEPTH = 1024;
	localparam int ROW_BITS   = 14;
	localparam int HEIGHT_W   = ROW_BITS + 1;
	localparam int FREE_AW    = $clog2(FREE_DEPTH);
	localparam int CNT_W      = $clog2(FREE_DEPTH + 1);
	localparam int STATUS_W   = 3;
	localparam int CFG_IDX_W  = 1;

	localparam logic [HEIGHT_W-1:0] ROW_LIMIT = HEIGHT_W'(1 << ROW_BITS);

	// request operation codes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_HEIGHT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_HEIGHT     = CFG_IDX_W'(1);

	typedef enum logic [STATUS_W-1:0] {
		ST_FROM_LIST = 3'd0,
		ST_FRESH     = 3'd1,
		ST_GREW      = 3'd2,
		ST_AT_LIMIT  = 3'd3,
		ST_FREED     = 3'd4,
		ST_IGNORED   = 3'd5,
		ST_DROPPED   = 3'd6
	} status_t;

	// zero acts as one, anything above the row space acts as the full row space
	function automatic logic [HEIGHT_W-1:0] clamp_height(input logic [HEIGHT_W-1:0] v);
		logic [HEIGHT_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = HEIGHT_W'(1);
		end else if (v > ROW_LIMIT) begin
			r = ROW_LIMIT;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/rsa_ifs.sv]
`default_nettype none

interface rsa_req_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 operation;
	logic signed [rsa_pkg::HEIGHT_W-1:0]  free_row;

	modport source (output valid, output operation, output free_row, input ready);
	modport sink   (input valid, input operation, input free_row, output ready);
endinterface

interface rsa_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [rsa_pkg::ROW_BITS-1:0]  row;
	logic [rsa_pkg::STATUS_W-1:0]  status;
	logic [rsa_pkg::HEIGHT_W-1:0]  height;

	modport source (output valid, output row, output status, output height, input ready);
	modport sink   (input valid, input row, input status, input height, output ready);
endinterface

interface rsa_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [rsa_pkg::CFG_IDX_W-1:0]  index;
	logic [rsa_pkg::HEIGHT_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/rsa_ram.sv]
`default_nettype none

module rsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [$clog2(DEPTH)-1:0]  addr,
	input  wire logic [WIDTH-1:0]          wdata,
	output logic      [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

[rtl/row_slot_allocator.sv]
`default_nettype none

// Row slot allocator: hands out row indices of a store whose height can grow.
// Channels: req (sink) carries operation and free_row; rsp (source) returns
// one transfer per request with row, status and height; cfg (sink) writes
// register 0 (initial height, also loads the current height) or register 1
// (maximum height). cfg is always ready; write it only while no request is
// in flight.
// Steps from request transfer to response valid:
//   allocate with an empty free list: result taken from the bump pointer
//   allocate from the free list:      read entry 0, read last, write
//   free of a negative row:           result marked ignored, no list access
//   free of a row:                    the duplicate
//                                     check reads one free list entry per
//                                     cycle through the single RAM port.
// One request is worked at a time. The response register lets a new request
// be taken while the previous response still waits; a finished result holds
// in its own state until the response register frees up.
// Reset clears the count and bump pointer and sets the height to one; the
// free list RAM needs no clearing pass because only entries below the count
// are ever read.
module row_slot_allocator (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rsa_req_if.sink    req,
	rsa_rsp_if.source  rsp,
	rsa_cfg_if.sink    cfg
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_ALAST  = 5'b00010,
		S_AWB    = 5'b00100,
		S_SCAN   = 5'b01000,
		S_RESULT = 5'b10000
	} state_t;

	state_t                              state_q;
	logic [rsa_pkg::CNT_W-1:0]           count_q;
	logic [rsa_pkg::CNT_W-1:0]           idx_q;
	logic                                pend_q;
	logic [rsa_pkg::ROW_BITS-1:0]        next_row_q;
	logic [rsa_pkg::HEIGHT_W-1:0]        cur_height_q;
	logic [rsa_pkg::HEIGHT_W-1:0]        max_height_q;
	logic [rsa_pkg::HEIGHT_W-1:0]        raw_q;
	logic [rsa_pkg::ROW_BITS-1:0]        res_row_q;
	rsa_pkg::status_t                    res_status_q;
	logic                                rsp_valid_q;
	logic [rsa_pkg::ROW_BITS-1:0]        rsp_row_q;
	rsa_pkg::status_t                    rsp_status_q;
	logic [rsa_pkg::HEIGHT_W-1:0]        rsp_height_q;

	logic                                mem_we;
	logic [rsa_pkg::FREE_AW-1:0]         mem_addr;
	logic [rsa_pkg::ROW_BITS-1:0]        mem_wdata;
	logic [rsa_pkg::ROW_BITS-1:0]        mem_rdata;

	logic                                req_fire;
	logic                                load_out;
	logic                                list_full;
	logic                                scan_hit;
	logic                                scan_end;
	logic                                free_neg;
	logic [rsa_pkg::HEIGHT_W-1:0]        bump_nxt;
	logic [rsa_pkg::HEIGHT_W:0]          grown;
	logic                                bump_grow;
	rsa_pkg::status_t                    bump_status;
	logic [rsa_pkg::HEIGHT_W-1:0]        last_idx;

	assign req.ready  = (state_q == S_IDLE);
	assign cfg.ready  = 1'b1;
	assign req_fire   = req.valid && req.ready;
	assign load_out   = (state_q == S_RESULT) && (!rsp_valid_q || rsp.ready);
	assign list_full  = (count_q == rsa_pkg::CNT_W'(rsa_pkg::FREE_DEPTH));
	assign scan_hit   = pend_q && (mem_rdata == raw_q[rsa_pkg::ROW_BITS-1:0]);
	assign scan_end   = (idx_q == count_q);
	assign free_neg   = req.free_row[rsa_pkg::HEIGHT_W-1];
	assign last_idx   = rsa_pkg::HEIGHT_W'(count_q) - 1'b1;

	assign rsp.valid  = rsp_valid_q;
	assign rsp.row    = rsp_row_q;
	assign rsp.status = rsp_status_q;
	assign rsp.height = rsp_height_q;

	// bump pointer path: advance, double on reaching the height, or park on
	// the last row when doubling would pass the maximum
	always_comb begin
		bump_nxt    = rsa_pkg::HEIGHT_W'({1'b0, next_row_q}) + 1'b1;
		grown       = {cur_height_q, 1'b0};
		bump_grow   = 1'b0;
		bump_status = rsa_pkg::ST_FRESH;
		if (bump_nxt >= cur_height_q) begin
			if (grown > {1'b0, rsa_pkg::clamp_height(max_height_q)}) begin
				bump_nxt    = cur_height_q - 1'b1;
				bump_status = rsa_pkg::ST_AT_LIMIT;
			end else begin
				bump_nxt    = cur_height_q;
				bump_grow   = 1'b1;
				bump_status = rsa_pkg::ST_GREW;
			end
		end
	end

	// RAM port: one access per cycle, read data is registered and arrives in the next cycle
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = '0;
		mem_wdata = mem_rdata;
		case (state_q)
			S_ALAST: begin
				mem_addr = last_idx[rsa_pkg::FREE_AW-1:0];
			end
			S_AWB: begin
				// move the last entry into the hole at entry 0
				mem_we    = 1'b1;
				mem_addr  = '0;
				mem_wdata = mem_rdata;
			end
			S_SCAN: begin
				if (!scan_hit && scan_end) begin
					mem_we    = !list_full;
					mem_addr  = count_q[rsa_pkg::FREE_AW-1:0];
					mem_wdata = raw_q[rsa_pkg::ROW_BITS-1:0];
				end else if (!scan_hit) begin
					mem_addr = idx_q[rsa_pkg::FREE_AW-1:0];
				end
			end
			default: begin
				mem_addr = '0;
			end
		endcase
	end

	rsa_ram #(
		.WIDTH(rsa_pkg::ROW_BITS),
		.DEPTH(rsa_pkg::FREE_DEPTH)
	) u_free_list (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			idx_q        <= '0;
			pend_q       <= 1'b0;
			next_row_q   <= '0;
			cur_height_q <= rsa_pkg::clamp_height(rsa_pkg::HEIGHT_W'(1));
			max_height_q <= rsa_pkg::ROW_LIMIT;
			rsp_valid_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						if (req.operation == rsa_pkg::OP_ALLOC) begin
							if (count_q != '0) begin
								state_q <= S_ALAST;
							end else begin
								next_row_q <= bump_nxt[rsa_pkg::ROW_BITS-1:0];
								if (bump_grow) begin
									cur_height_q <= grown[rsa_pkg::HEIGHT_W-1:0];
								end
								state_q <= S_RESULT;
							end
						end else if (free_neg) begin
							state_q <= S_RESULT;
						end else begin
							idx_q   <= '0;
							pend_q  <= 1'b0;
							state_q <= S_SCAN;
						end
					end
				end
				S_ALAST: begin
					state_q <= S_AWB;
				end
				S_AWB: begin
					count_q <= count_q - 1'b1;
					state_q <= S_RESULT;
				end
				S_SCAN: begin
					if (scan_hit) begin
						state_q <= S_RESULT;
					end else if (scan_end) begin
						if (!list_full) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= S_RESULT;
					end else begin
						idx_q  <= idx_q + 1'b1;
						pend_q <= 1'b1;
					end
				end
				S_RESULT: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// response register: hold until the receiver takes the transfer
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			if (cfg.valid && cfg.ready) begin
				if (cfg.index == rsa_pkg::REG_INITIAL_HEIGHT) begin
					cur_height_q <= rsa_pkg::clamp_height(cfg.data);
				end else if (cfg.index == rsa_pkg::REG_MAX_HEIGHT) begin
					max_height_q <= cfg.data;
				end
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					raw_q <= req.free_row;
					if (req.operation == rsa_pkg::OP_ALLOC) begin
						res_row_q    <= next_row_q;
						res_status_q <= bump_status;
					end else if (free_neg) begin
						res_row_q    <= '0;
						res_status_q <= rsa_pkg::ST_IGNORED;
					end else begin
						res_row_q    <= req.free_row[rsa_pkg::ROW_BITS-1:0];
						res_status_q <= rsa_pkg::ST_FREED;
					end
				end
			end
			S_ALAST: begin
				res_row_q    <= mem_rdata;
				res_status_q <= rsa_pkg::ST_FROM_LIST;
			end
			S_SCAN: begin
				if (scan_hit) begin
					res_status_q <= rsa_pkg::ST_IGNORED;
				end else if (scan_end && list_full) begin
					res_status_q <= rsa_pkg::ST_DROPPED;
				end
			end
			default: begin
			end
		endcase

		if (load_out) begin
			rsp_row_q    <= res_row_q;
			rsp_status_q <= res_status_q;
			rsp_height_q <= cur_height_q;
		end
	end

	// the list never holds more than its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= rsa_pkg::CNT_W'(rsa_pkg::FREE_DEPTH))
		else $error("free list count beyond depth");

	// the count moves by at most one per cycle
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> (count_q == $past(count_q) + 1'b1 ||
			count_q == $past(count_q) - 1'b1))
		else $error("free list count jumped");

	// the height is always a legal store height
	a_height_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_height_q != '0 && cur_height_q <= rsa_pkg::ROW_LIMIT)
		else $error("store height out of range");

	// the duplicate scan never reads past the filled part of the list
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> idx_q <= count_q)
		else $error("scan index past free count");

	// a list write only happens on a refill of entry 0 or an append
	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_AWB || (state_q == S_SCAN && scan_end)))
		else $error("free list written outside refill or append");

endmodule

`default_nettype wire
